// File: rtl/mbrr_pkg.sv
// Shared types, constants and CRC function for the Modbus read-register responder.
`timescale 1ns / 1ps
`default_nettype none

package mbrr_pkg;

  localparam int WIN_LEN      = 8;
  localparam int MAX_REGS_DEF = 125;

  localparam logic [7:0]  SLAVE_ADDR_RST    = 8'h01;
  localparam logic [7:0]  FC_READ_HOLDING   = 8'h03;
  localparam logic [7:0]  FC_READ_INPUT     = 8'h04;
  localparam logic [7:0]  EXC_FLAG          = 8'h80;
  localparam logic [7:0]  EXC_ILLEGAL_VALUE = 8'h03;
  localparam logic [7:0]  CHECK_LAST_IDX    = 8'd5;
  localparam logic [7:0]  FRAME_OVERHEAD    = 8'd5;
  localparam logic [15:0] REG_METRIC_0      = 16'h0004;
  localparam logic [15:0] REG_METRIC_1      = 16'h0006;
  localparam logic [15:0] REG_METRIC_2      = 16'h0008;
  localparam logic [15:0] REG_UNMAPPED      = 16'hFFFF;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_VERIFY,
    ST_RESP
  } mbrr_state_t;

  typedef struct packed {
    logic win_push;
    logic metric_wr;
    logic crc_clear;
    logic crc_step;
    logic win_consume;
    logic win_shift;
    logic resp_start;
    logic resp_step;
  } mbrr_cmd_t;

  typedef struct packed {
    logic fill_is_last;
    logic check_done;
    logic frame_ok;
    logic addr_match;
    logic resp_last;
    logic can_step;
  } mbrr_status_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mbrr_ctrl.sv
// Controller state machine: sequences receive, CRC check, verify and response.
`timescale 1ns / 1ps
`default_nettype none

module mbrr_ctrl
  import mbrr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_op,
  output logic              in_stall,
  input  wire mbrr_status_t st,
  output mbrr_cmd_t         cmd
);

  mbrr_state_t state_r, state_nxt;
  logic        accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    accept    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (accept) begin
          if (in_op) begin
            cmd.metric_wr = 1'b1;
          end else begin
            cmd.win_push = 1'b1;
            if (st.fill_is_last) begin
              cmd.crc_clear = 1'b1;
              state_nxt     = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        cmd.crc_step = 1'b1;
        if (st.check_done) state_nxt = ST_VERIFY;
      end
      ST_VERIFY: begin
        state_nxt = ST_IDLE;
        if (st.frame_ok) begin
          cmd.win_consume = 1'b1;
          if (st.addr_match) begin
            cmd.resp_start = 1'b1;
            state_nxt      = ST_RESP;
          end
        end else begin
          cmd.win_shift = 1'b1;
        end
      end
      ST_RESP: begin
        if (st.can_step) begin
          cmd.resp_step = 1'b1;
          if (st.resp_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mbrr_datapath.sv
// Datapath: frame window, metrics, CRC unit, response byte generator and packer.
`timescale 1ns / 1ps
`default_nettype none

module mbrr_datapath
  import mbrr_pkg::*;
#(
  parameter int MAX_REGS = MAX_REGS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [7:0]   in_rx_byte,
  input  wire logic [1:0]   in_metric_select,
  input  wire logic [15:0]  in_metric_value,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_data,
  input  wire mbrr_cmd_t    cmd,
  output mbrr_status_t      st,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_tx_byte_0,
  output logic [7:0]        out_tx_byte_1,
  output logic [7:0]        out_tx_byte_2,
  output logic [7:0]        out_tx_byte_3,
  output logic [2:0]        out_bytes_valid,
  output logic              out_last
);

  localparam logic [15:0] MaxRegs = 16'(MAX_REGS);

  logic [7:0]  win_r [WIN_LEN];
  logic [3:0]  fill_r;
  logic [15:0] metric_r [3];
  logic [7:0]  slave_addr_r;
  logic [15:0] crc_r;
  logic [7:0]  idx_r;
  logic [7:0]  len_r;
  logic        exc_r;
  logic [15:0] reg_addr_r;
  logic [7:0]  pk_r [3];
  logic [1:0]  pk_cnt_r;
  logic        out_valid_r;
  logic [7:0]  tx_r [4];
  logic [2:0]  bv_r;
  logic        last_r;

  logic [7:0]  fc;
  logic [15:0] first_reg_addr;
  logic [15:0] reg_count;
  logic        exc_nxt;
  logic [7:0]  len_nxt;
  logic        last_byte;
  logic        crc_lo_byte;
  logic        crc_byte;
  logic [15:0] reg_val;
  logic [7:0]  tx_cur;
  logic        emit;
  logic        out_free;

  assign cfg_ready      = 1'b1;
  assign fc             = win_r[1];
  assign first_reg_addr = {win_r[2], win_r[3]};
  assign reg_count      = {win_r[4], win_r[5]};
  assign exc_nxt        = (reg_count == 16'd0) || (reg_count > MaxRegs);
  assign len_nxt        = exc_nxt ? FRAME_OVERHEAD : FRAME_OVERHEAD + {reg_count[6:0], 1'b0};

  assign last_byte   = idx_r == len_r - 8'd1;
  assign crc_lo_byte = idx_r == len_r - 8'd2;
  assign crc_byte    = last_byte || crc_lo_byte;

  always_comb begin
    unique case (reg_addr_r)
      REG_METRIC_0: reg_val = metric_r[0];
      REG_METRIC_1: reg_val = metric_r[1];
      REG_METRIC_2: reg_val = metric_r[2];
      default:      reg_val = REG_UNMAPPED;
    endcase
  end

  always_comb begin
    if (last_byte) begin
      tx_cur = crc_r[15:8];
    end else if (crc_lo_byte) begin
      tx_cur = crc_r[7:0];
    end else if (idx_r == 8'd0) begin
      tx_cur = slave_addr_r;
    end else if (idx_r == 8'd1) begin
      tx_cur = exc_r ? (EXC_FLAG | fc) : fc;
    end else if (idx_r == 8'd2) begin
      tx_cur = exc_r ? EXC_ILLEGAL_VALUE : len_r - FRAME_OVERHEAD;
    end else begin
      tx_cur = idx_r[0] ? reg_val[15:8] : reg_val[7:0];
    end
  end

  assign emit     = (pk_cnt_r == 2'd3) || last_byte;
  assign out_free = !out_valid_r || !out_stall;

  assign st.fill_is_last = fill_r == 4'(WIN_LEN - 1);
  assign st.check_done   = idx_r == CHECK_LAST_IDX;
  assign st.frame_ok     = ((fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT))
                           && (crc_r == {win_r[7], win_r[6]});
  assign st.addr_match   = win_r[0] == slave_addr_r;
  assign st.resp_last    = last_byte;
  assign st.can_step     = !emit || out_free;

  // frame window and payload registers
  always_ff @(posedge clk) begin
    if (cmd.win_push) win_r[fill_r[2:0]] <= in_rx_byte;
    if (cmd.win_shift) begin
      for (int i = 0; i < WIN_LEN - 1; i++) win_r[i] <= win_r[i + 1];
    end
    if (cmd.resp_start) begin
      len_r      <= len_nxt;
      exc_r      <= exc_nxt;
      reg_addr_r <= first_reg_addr;
    end
    if (cmd.resp_step) begin
      if (!crc_byte && !idx_r[0] && idx_r > 8'd2) reg_addr_r <= reg_addr_r + 16'd1;
      if (!emit) pk_r[pk_cnt_r] <= tx_cur;
    end
    if (cmd.crc_clear || cmd.resp_start) begin
      crc_r <= CRC_INIT;
      idx_r <= 8'd0;
    end else if (cmd.crc_step) begin
      crc_r <= crc16_byte(crc_r, win_r[idx_r[2:0]]);
      idx_r <= idx_r + 8'd1;
    end else if (cmd.resp_step) begin
      if (!crc_byte) crc_r <= crc16_byte(crc_r, tx_cur);
      idx_r <= idx_r + 8'd1;
    end
    if (cmd.resp_step && emit) begin
      for (int j = 0; j < 4; j++) begin
        if (2'(j) < pk_cnt_r && j < 3) begin
          tx_r[j] <= pk_r[j[1:0]];
        end else if (3'(j) == {1'b0, pk_cnt_r}) begin
          tx_r[j] <= tx_cur;
        end else begin
          tx_r[j] <= 8'h00;
        end
      end
      bv_r   <= {1'b0, pk_cnt_r} + 3'd1;
      last_r <= last_byte;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      slave_addr_r <= SLAVE_ADDR_RST;
      pk_cnt_r     <= '0;
      out_valid_r  <= 1'b0;
      for (int m = 0; m < 3; m++) metric_r[m] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) slave_addr_r <= cfg_data;
      if (cmd.metric_wr && in_metric_select != 2'd3) metric_r[in_metric_select] <= in_metric_value;
      if (cmd.win_push) begin
        fill_r <= fill_r + 4'd1;
      end else if (cmd.win_consume) begin
        fill_r <= '0;
      end else if (cmd.win_shift) begin
        fill_r <= 4'(WIN_LEN - 1);
      end
      if (cmd.resp_start) begin
        pk_cnt_r <= '0;
      end else if (cmd.resp_step) begin
        pk_cnt_r <= emit ? 2'd0 : pk_cnt_r + 2'd1;
      end
      if (cmd.resp_step && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tx_byte_0   = tx_r[0];
  assign out_tx_byte_1   = tx_r[1];
  assign out_tx_byte_2   = tx_r[2];
  assign out_tx_byte_3   = tx_r[3];
  assign out_bytes_valid = bv_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

// File: rtl/modbus_read_register_responder.sv
// Top level of the Modbus RTU read-register responder.
//
//   channel  direction  handshake              content
//   in_      input      in_valid / in_stall    received byte or metric update
//   out_     output     out_valid / out_stall  response group of up to four bytes
//   cfg_     input      cfg_valid / cfg_ready  slave address
//
// A metric update or a byte that leaves the window short is taken while idle.
// A byte that fills the window starts 6 CRC steps (one byte per step) and a
// verify step; a valid request for this slave then steps out the response bytes.
// Reset clears the window fill count, metrics and sets the slave address to 1.
// Input is stalled in check, verify and response; output stalls hold the generator.
`timescale 1ns / 1ps
`default_nettype none

module modbus_read_register_responder
  import mbrr_pkg::*;
#(
  parameter int MAX_REGS = MAX_REGS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [1:0]  in_metric_select,
  input  wire logic [15:0] in_metric_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_tx_byte_0,
  output logic [7:0]       out_tx_byte_1,
  output logic [7:0]       out_tx_byte_2,
  output logic [7:0]       out_tx_byte_3,
  output logic [2:0]       out_bytes_valid,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  mbrr_cmd_t    cmd;
  mbrr_status_t st;

  mbrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mbrr_datapath #(
    .MAX_REGS (MAX_REGS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_rx_byte       (in_rx_byte),
    .in_metric_select (in_metric_select),
    .in_metric_value  (in_metric_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_byte_0    (out_tx_byte_0),
    .out_tx_byte_1    (out_tx_byte_1),
    .out_tx_byte_2    (out_tx_byte_2),
    .out_tx_byte_3    (out_tx_byte_3),
    .out_bytes_valid  (out_bytes_valid),
    .out_last         (out_last)
  );

  a_full_window_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.win_push && st.fill_is_last) |=> in_stall)
    else $error("window full but input not stalled for check");

  a_short_group_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bytes_valid != 3'd4) |-> out_last)
    else $error("partial transfer group not marked last");

  a_resp_end_releases: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resp_step && st.resp_last) |=> !in_stall)
    else $error("input still stalled after final response byte");

endmodule

`default_nettype wire

// File: tb/modbus_read_register_responder_tb.sv
// Self-checking testbench for the Modbus read-register responder.
`timescale 1ns / 1ps

module modbus_read_register_responder_tb
  import mbrr_pkg::*;
;

  localparam logic       OP_RX_BYTE     = 1'b0;
  localparam logic       OP_METRIC      = 1'b1;
  localparam logic [1:0] MSEL_REG4      = 2'd0;
  localparam logic [1:0] MSEL_REG6      = 2'd1;
  localparam logic [1:0] MSEL_REG8      = 2'd2;
  localparam logic [1:0] MSEL_NONE      = 2'd3;
  localparam int         SETTLE_CYCLES  = 16;
  localparam int         WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic        op;
    logic [7:0]  rx_byte;
    logic [1:0]  metric_select;
    logic [15:0] metric_value;
  } rx_item_t;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      nvalid;
    logic            last;
  } tx_group_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_op = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic [1:0]  in_metric_select = '0;
  logic [15:0] in_metric_value = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_tx_byte_0;
  logic [7:0]  out_tx_byte_1;
  logic [7:0]  out_tx_byte_2;
  logic [7:0]  out_tx_byte_3;
  logic [2:0]  out_bytes_valid;
  logic        out_last;
  logic        cfg_ready;

  wire rx_fire  = in_valid && !in_stall;
  wire tx_fire  = out_valid && !out_stall;
  wire cfg_fire = cfg_valid && cfg_ready;

  rx_item_t  rx_items_pending [$];
  rx_item_t  rx_offered;
  tx_group_t tx_groups_due [$];

  // predictor state
  logic [7:0]  frame_win [WIN_LEN];
  int          win_fill = 0;
  logic [15:0] metric_regs [3];
  logic [7:0]  own_address = SLAVE_ADDR_RST;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int rx_queued = 0;
  int rx_accepted = 0;
  int tx_groups_seen = 0;
  int mismatches = 0;
  int cfg_writes = 0;
  int frames_answered = 0;
  int exceptions_due = 0;
  int requests_ignored = 0;

  modbus_read_register_responder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_rx_byte       (in_rx_byte),
    .in_metric_select (in_metric_select),
    .in_metric_value  (in_metric_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_byte_0    (out_tx_byte_0),
    .out_tx_byte_1    (out_tx_byte_1),
    .out_tx_byte_2    (out_tx_byte_2),
    .out_tx_byte_3    (out_tx_byte_3),
    .out_bytes_valid  (out_bytes_valid),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reflected CRC-16, fed one data bit at a time, LSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic fb;
    for (int b = 0; b < 8; b++) begin
      fb  = crc[0] ^ data[b];
      crc = {1'b0, crc[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return crc;
  endfunction

  task automatic predict_rx_item(input rx_item_t it);
    logic [7:0]  resp [0:259];
    logic [15:0] crc;
    logic [15:0] first_reg;
    logic [15:0] reg_count;
    logic [15:0] reg_addr;
    logic [15:0] word;
    int          n;
    tx_group_t   grp;
    if (it.op == OP_METRIC) begin
      if (it.metric_select != MSEL_NONE) metric_regs[it.metric_select] = it.metric_value;
      return;
    end
    if (win_fill >= WIN_LEN) win_fill = WIN_LEN - 1;
    frame_win[win_fill] = it.rx_byte;
    win_fill++;
    if (win_fill < WIN_LEN) return;
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) crc = crc16_step(crc, frame_win[i]);
    if (!((frame_win[1] == FC_READ_HOLDING || frame_win[1] == FC_READ_INPUT) &&
          crc == {frame_win[7], frame_win[6]})) begin
      for (int i = 0; i < WIN_LEN - 1; i++) frame_win[i] = frame_win[i + 1];
      win_fill = WIN_LEN - 1;
      return;
    end
    win_fill = 0;
    if (frame_win[0] != own_address) begin
      requests_ignored++;
      return;
    end
    frames_answered++;
    first_reg = {frame_win[2], frame_win[3]};
    reg_count = {frame_win[4], frame_win[5]};
    resp[0] = own_address;
    n = 3;
    if (reg_count == 0 || reg_count > MAX_REGS_DEF) begin
      resp[1] = EXC_FLAG | frame_win[1];
      resp[2] = EXC_ILLEGAL_VALUE;
      exceptions_due++;
    end else begin
      resp[1] = frame_win[1];
      resp[2] = 8'(reg_count << 1);
      for (int i = 0; i < reg_count; i++) begin
        reg_addr = 16'(first_reg + i);
        case (reg_addr)
          REG_METRIC_0: word = metric_regs[MSEL_REG4];
          REG_METRIC_1: word = metric_regs[MSEL_REG6];
          REG_METRIC_2: word = metric_regs[MSEL_REG8];
          default:      word = REG_UNMAPPED;
        endcase
        resp[n]     = word[15:8];
        resp[n + 1] = word[7:0];
        n += 2;
      end
    end
    crc = CRC_INIT;
    for (int i = 0; i < n; i++) crc = crc16_step(crc, resp[i]);
    resp[n]     = crc[7:0];
    resp[n + 1] = crc[15:8];
    n += 2;
    for (int base = 0; base < n; base += 4) begin
      grp        = '0;
      grp.nvalid = 3'((n - base > 4) ? 4 : n - base);
      for (int k = 0; k < 4; k++) if (k < n - base) grp.data[k] = resp[base + k];
      grp.last   = (base + 4 >= n);
      tx_groups_due.push_back(grp);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (rx_fire) begin
        predict_rx_item(rx_offered);
        rx_accepted++;
      end
      if (!in_valid || rx_fire) begin
        if (rx_items_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_offered       = rx_items_pending.pop_front();
          in_valid         <= 1'b1;
          in_op            <= rx_offered.op;
          in_rx_byte       <= rx_offered.rx_byte;
          in_metric_select <= rx_offered.metric_select;
          in_metric_value  <= rx_offered.metric_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_tx
    tx_group_t seen;
    tx_group_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (tx_fire) begin
        seen.data   = {out_tx_byte_3, out_tx_byte_2, out_tx_byte_1, out_tx_byte_0};
        seen.nvalid = out_bytes_valid;
        seen.last   = out_last;
        tx_groups_seen++;
        if (tx_groups_due.size() == 0) begin
          $display("%0t: unexpected group: expected none, got bytes %h valid %0d last %0b",
                   $time, seen.data, seen.nvalid, seen.last);
          mismatches++;
        end else begin
          want = tx_groups_due.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (seen.data[k] !== want.data[k]) begin
              $display("%0t: tx_byte_%0d expected %h got %h",
                       $time, k, want.data[k], seen.data[k]);
              mismatches++;
            end
          end
          if (seen.nvalid !== want.nvalid) begin
            $display("%0t: bytes_valid expected %0d got %0d", $time, want.nvalid, seen.nvalid);
            mismatches++;
          end
          if (seen.last !== want.last) begin
            $display("%0t: last expected %0b got %0b", $time, want.last, seen.last);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || rx_fire || tx_fire || cfg_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("modbus_read_register_responder_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(input logic op, input logic [7:0] rx, input logic [1:0] sel,
                           input logic [15:0] val);
    rx_item_t it;
    it.op            = op;
    it.rx_byte       = rx;
    it.metric_select = sel;
    it.metric_value  = val;
    rx_items_pending.push_back(it);
    rx_queued++;
  endtask

  task automatic push_rx_byte(input logic [7:0] b);
    push_item(OP_RX_BYTE, b, 2'($urandom_range(3)), 16'($urandom));
  endtask

  task automatic push_metric(input logic [1:0] sel, input logic [15:0] val);
    push_item(OP_METRIC, 8'($urandom), sel, val);
  endtask

  task automatic push_request(input logic [7:0] addr, input logic [7:0] fc,
                              input logic [15:0] first_reg, input logic [15:0] reg_count,
                              input bit spoil);
    logic [7:0]  frame [8];
    logic [15:0] crc;
    int          hit;
    frame[0] = addr;
    frame[1] = fc;
    frame[2] = first_reg[15:8];
    frame[3] = first_reg[7:0];
    frame[4] = reg_count[15:8];
    frame[5] = reg_count[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) crc = crc16_step(crc, frame[i]);
    frame[6] = crc[7:0];
    frame[7] = crc[15:8];
    if (spoil) begin
      hit        = $urandom_range(7);
      frame[hit] = frame[hit] ^ (8'h01 << $urandom_range(7));
    end
    for (int i = 0; i < 8; i++) push_rx_byte(frame[i]);
  endtask

  // mostly well-formed requests; the rest metric updates, stray bytes and bad frames
  task automatic push_random_traffic(input int target, input logic [7:0] own);
    int          made;
    int          pick;
    int          stray;
    logic [7:0]  addr;
    logic [7:0]  fc;
    logic [15:0] first_reg;
    logic [15:0] reg_count;
    logic [1:0]  sel;
    made = 0;
    while (made < target) begin
      addr = ($urandom_range(9) < 6) ? own : 8'($urandom_range(255));
      fc   = $urandom_range(1) ? FC_READ_HOLDING : FC_READ_INPUT;
      pick = $urandom_range(9);
      if (pick < 5) first_reg = 16'($urandom_range(10));
      else if (pick < 7) first_reg = 16'hFFF8 + 16'($urandom_range(7));
      else first_reg = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 66) reg_count = 16'($urandom_range(1, 8));
      else if (pick < 74) reg_count = 16'h0000;
      else if (pick < 82) reg_count = 16'($urandom_range(MAX_REGS_DEF + 1, 16'hFFFF));
      else if (pick < 88) reg_count = 16'(MAX_REGS_DEF);
      else reg_count = 16'($urandom_range(9, MAX_REGS_DEF - 1));
      pick = $urandom_range(99);
      if (pick < 64) begin
        push_request(addr, fc, first_reg, reg_count, 1'b0);
        made += 8;
      end else if (pick < 82) begin
        sel = 2'($urandom_range(3));
        push_metric(sel, 16'($urandom));
        if (sel != MSEL_NONE) made++;
      end else if (pick < 91) begin
        stray = $urandom_range(1, 3);
        repeat (stray) push_rx_byte(8'($urandom));
        made += stray;
      end else if (pick < 96) begin
        push_request(addr, fc, first_reg, reg_count, 1'b1);
        made += 8;
      end else begin
        fc = 8'($urandom);
        if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) fc = fc | EXC_FLAG;
        push_request(addr, fc, first_reg, reg_count, 1'b0);
        made += 8;
      end
    end
  endtask

  task automatic wait_until_idle();
    while (rx_accepted != rx_queued || tx_groups_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slave_address(input logic [7:0] addr);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    own_address = addr;
    cfg_writes++;
  endtask

  initial begin
    foreach (metric_regs[i]) metric_regs[i] = 16'h0000;
    foreach (frame_win[i]) frame_win[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 7;
    recv_stall_pct = 68;
    push_metric(MSEL_REG4, 16'hFFFF);
    push_metric(MSEL_REG6, 16'h0000);
    push_metric(MSEL_REG8, 16'h8001);
    push_metric(MSEL_NONE, 16'h1234);
    push_metric(MSEL_REG6, 16'h5AC3);
    // registers 4..8, mixing metrics with unmapped addresses
    push_request(SLAVE_ADDR_RST, FC_READ_HOLDING, REG_METRIC_0, 16'd5, 1'b0);
    // zero count gives an exception
    push_request(SLAVE_ADDR_RST, FC_READ_INPUT, 16'hFFFF, 16'h0000, 1'b0);
    // request for another slave is consumed silently
    push_request(8'hFF, FC_READ_HOLDING, REG_METRIC_1, 16'd1, 1'b0);
    wait_until_idle();

    write_slave_address(8'h00);
    push_random_traffic(130, 8'h00);
    wait_until_idle();

    send_idle_pct  = 68;
    recv_stall_pct = 7;
    write_slave_address(8'hFF);
    push_random_traffic(130, 8'hFF);
    wait_until_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_slave_address(8'($urandom_range(2, 254)));
    push_random_traffic(130, own_address);
    wait_until_idle();

    $display("covered %0d input transfers and %0d response groups across %0d slave addresses",
             rx_accepted, tx_groups_seen, cfg_writes + 1);
    $display("requests answered %0d (exceptions %0d), requests for other slaves %0d",
             frames_answered, exceptions_due, requests_ignored);
    if (mismatches == 0) begin
      $display("modbus_read_register_responder_tb passed");
    end else begin
      $display("modbus_read_register_responder_tb failed");
    end
    $finish;
  end

endmodule
